### rtl/hspd_pkg.sv
// Package for the humidity sensor pulse decoder.
// Holds the frame queue types, status codes and fixed frame constants.
// No dependencies; every other file in rtl imports it.
package hspd_pkg;

  // Fixed frame layout
  localparam int DATA_BITS = 40;
  localparam int CNT_W     = 6;
  localparam int DUR_W     = 15;
  localparam int QDEPTH    = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;
  localparam logic [CNT_W-1:0] LAST_DATA = 6'd40;
  localparam logic [CNT_W-1:0] FIRST_DATA = 6'd1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOO_FEW = 2'd1,
    ST_BAD_SUM = 2'd2
  } status_t;

  // One finished frame as handed from the front end to the back end
  typedef struct packed {
    logic [DATA_BITS-1:0] bits;
    logic                 too_few;
  } frame_t;

  // Queue occupancy as seen by the front and back ends
  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] level;
  } qstat_t;

endpackage

### rtl/hspd_front.sv
// Front end of the pulse decoder: classifies each pulse and assembles frames.
// Pushes one finished frame into the queue on the frame-end pulse.
// Depends on hspd_pkg.
module hspd_front import hspd_pkg::*; #(
  parameter int MIN_PULSES = 42
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [DUR_W-1:0] high_duration,
  input  logic             frame_end,
  input  logic [DUR_W-1:0] bit_threshold,
  output logic             push,
  output frame_t           push_frame
);

  localparam logic [CNT_W-1:0] MinCount = CNT_W'(MIN_PULSES);

  logic [DATA_BITS-1:0] bits_r, bits_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 data_pulse;
  logic                 bit_val;

  // Decode the current pulse and update the shift register and counter.
  always_comb begin
    data_pulse = (count_r >= FIRST_DATA) && (count_r <= LAST_DATA);
    bit_val    = (high_duration >= bit_threshold);
    bits_nxt   = data_pulse ? {bits_r[DATA_BITS-2:0], bit_val} : bits_r;
    count_nxt  = (count_r != COUNT_MAX) ? count_r + 1'b1 : count_r;
  end

  // The frame as it stands after this pulse goes to the queue.
  assign push               = accept && frame_end;
  assign push_frame.bits    = bits_nxt;
  assign push_frame.too_few = (count_nxt < MinCount);

  // Frame state clears after the frame-end pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      if (frame_end) begin
        bits_r  <= '0;
        count_r <= '0;
      end else begin
        bits_r  <= bits_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

### rtl/hspd_queue.sv
// Two-entry frame queue between the front and back ends of the decoder.
// Register based; write and read in the same cycle are allowed.
// Depends on hspd_pkg.
module hspd_queue import hspd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_frame,
  input  logic   pop,
  output frame_t head,
  output qstat_t stat
);

  frame_t     entries_r [QDEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] level_r, level_nxt;

  // Occupancy flags
  assign stat.full  = (level_r == 2'(QDEPTH));
  assign stat.empty = (level_r == 2'd0);
  assign stat.level = level_r;
  assign head       = entries_r[rd_ptr_r];

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 2'd1;
    end else if (pop && !push) begin
      level_nxt = level_r - 2'd1;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_frame;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      level_r <= level_nxt;
    end
  end

endmodule

### rtl/hspd_back.sv
// Back end of the pulse decoder: checks the checksum, scales temperature
// and holds the result in an output register. Depends on hspd_pkg.
module hspd_back import hspd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  frame_t      head,
  input  qstat_t      stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_humidity_percent,
  output logic [11:0] out_temperature_tenths
);

  logic [7:0]  h_int, h_frac, t_int, t_frac, sum_byte, calc_sum;
  logic [11:0] temp_calc;
  status_t     status_calc;

  logic        valid_r;
  status_t     status_r;
  logic [7:0]  hum_r;
  logic [11:0] temp_r;

  // Split the frame into bytes and evaluate it.
  always_comb begin
    h_int     = head.bits[39:32];
    h_frac    = head.bits[31:24];
    t_int     = head.bits[23:16];
    t_frac    = head.bits[15:8];
    sum_byte  = head.bits[7:0];
    calc_sum  = h_int + h_frac + t_int + t_frac;
    temp_calc = 12'({t_int, 3'b000}) + 12'({t_int, 1'b0}) + 12'(t_frac);
    if (head.too_few) begin
      status_calc = ST_TOO_FEW;
    end else if (calc_sum != sum_byte) begin
      status_calc = ST_BAD_SUM;
    end else begin
      status_calc = ST_OK;
    end
  end

  // Take a frame when one waits and the output register is free.
  assign pop = !stat.empty && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload; fields are zero unless the frame is good.
  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= status_calc;
      hum_r    <= (status_calc == ST_OK) ? h_int : 8'd0;
      temp_r   <= (status_calc == ST_OK) ? temp_calc : 12'd0;
    end
  end

  assign out_valid              = valid_r;
  assign out_status             = status_r;
  assign out_humidity_percent   = hum_r;
  assign out_temperature_tenths = temp_r;

endmodule

### rtl/humidity_sensor_pulse_decoder.sv
// Top level of the single-wire humidity sensor pulse decoder.
// Instantiates hspd_front, hspd_queue and hspd_back; depends on hspd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction per measured pulse,
//   its high time in ticks and a flag on the last pulse of the frame. The
//   first pulse of a frame is the start pulse; the next 40 form the data.
//   Output channel (out_valid / out_stall): one transaction per frame, sent
//   for the frame-end pulse, with status, humidity and temperature in tenths.
//   Config channel (cfg_valid / cfg_ready): writes the bit threshold; it is
//   always ready and should be written only while the decoder is idle.
// Timing:
//   One pulse is accepted every cycle unless in_stall is high. The frame-end
//   pulse pushes the finished frame into the two-entry frame queue; the back
//   end then pops it through the checksum and scaling logic into the output
//   register.
// Reset and back-pressure:
//   Reset clears the frame state and the queue and sets the threshold to 35.
//   While the receiver stalls, the result holds in the output register and
//   the queue absorbs up to two more frames; in_stall rises only when the
//   queue is full.
module humidity_sensor_pulse_decoder import hspd_pkg::*; #(
  parameter int MIN_PULSES = 42
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [14:0] in_high_duration,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_humidity_percent,
  output logic [11:0] out_temperature_tenths,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_bit_threshold
);

  logic [DUR_W-1:0] threshold_r;
  logic             in_accept;
  logic             push;
  logic             pop;
  frame_t           push_frame;
  frame_t           head;
  qstat_t           qstat;

  // Threshold register, written whenever a config transaction arrives.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= 15'd35;
    end else if (cfg_valid && cfg_ready) begin
      threshold_r <= cfg_bit_threshold;
    end
  end

  // Input back-pressure comes from the frame queue.
  assign in_stall  = qstat.full;
  assign in_accept = in_valid && !in_stall;

  hspd_front #(
    .MIN_PULSES(MIN_PULSES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .high_duration(in_high_duration),
    .frame_end    (in_frame_end),
    .bit_threshold(threshold_r),
    .push         (push),
    .push_frame   (push_frame)
  );

  hspd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_frame(push_frame),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  hspd_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head                  (head),
    .stat                  (qstat),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_humidity_percent  (out_humidity_percent),
    .out_temperature_tenths(out_temperature_tenths)
  );

  // A frame-end transaction always leaves at least one frame queued.
  a_frame_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_frame_end |=> !qstat.empty)
    else $error("frame lost after frame-end pulse");

  // The queue never holds more than its depth.
  a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.level <= 2'(QDEPTH))
    else $error("frame queue overfilled");

  // Failed frames report zero humidity and temperature.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_humidity_percent == 8'd0) && (out_temperature_tenths == 12'd0))
    else $error("nonzero fields on a failed frame");

  // A good frame stays within the scaled temperature range.
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |-> out_temperature_tenths <= 12'd2805)
    else $error("temperature out of range");

endmodule
